[rtl/htts_pkg.sv]
// ============================================================================
// htts_pkg
// Shared constants, types and small hash helpers for the tile threshold core.
// ============================================================================
package htts_pkg;

    localparam int NSTAGE = 12;

    localparam logic [31:0] GOLD_MUL      = 32'h9e3779b9;
    localparam logic [31:0] CHAN_MUL      = 32'h85ebca6b;
    localparam logic [31:0] DEPTH_MUL     = 32'hc2b2ae35;
    localparam logic [31:0] MIX_MUL_A     = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B     = 32'h846ca68b;
    localparam logic [31:0] PERM_MUL_A    = 32'he95e1dd5;
    localparam logic [31:0] PERM_MUL_B    = 32'h7feb352d;
    localparam logic [31:0] SCRAMBLE_SALT = 32'h243f6a88;
    localparam logic [31:0] OFFX_ADD      = 32'h68bc21eb;
    localparam logic [31:0] OFFY_XOR      = 32'h02e5be93;
    localparam logic [31:0] SCRX_KEY      = 32'ha511e9b3;
    localparam logic [31:0] SCRY_KEY      = 32'h63d83595;
    localparam logic [31:0] RANK_KEY      = 32'hb7e15162;
    localparam logic [31:0] JIT_X_MUL     = 32'h6a09e667;
    localparam logic [31:0] JIT_Y_MUL     = 32'hbb67ae85;
    localparam logic [28:0] SCALE_MUL     = 29'd65551;
    localparam logic [28:0] SCALE_ROUND   = 29'd2055;

    localparam logic REG_FRAME_INDEX   = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    typedef struct packed {
        logic [31:0] frame_index;
        logic [7:0]  channel_count;
    } cfg_t;

    function automatic logic [7:0] mod_step(input logic [7:0] rem, input logic b,
                                            input logic [7:0] d);
        logic [8:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[7:0];
    endfunction

    function automatic logic [5:0] perm6_a(input logic [5:0] v, input logic [5:0] k);
        logic [5:0] x;
        x = v ^ k;
        return x * PERM_MUL_A[5:0];
    endfunction

    function automatic logic [5:0] perm6_b(input logic [5:0] v, input logic [5:0] k);
        logic [5:0] x;
        x = v ^ (v >> 3);
        x = x ^ (x >> 5);
        x = x ^ k;
        return x * PERM_MUL_B[5:0];
    endfunction

    function automatic logic [11:0] perm12_a(input logic [11:0] v, input logic [11:0] k);
        logic [11:0] x;
        x = v ^ k;
        return x * PERM_MUL_A[11:0];
    endfunction

    function automatic logic [11:0] perm12_b(input logic [11:0] v, input logic [11:0] k);
        logic [11:0] x;
        x = v ^ (v >> 3);
        x = x ^ (x >> 5);
        x = x ^ k;
        return x * PERM_MUL_B[11:0];
    endfunction

    function automatic logic [11:0] interleave6(input logic [5:0] x, input logic [5:0] y);
        logic [11:0] r;
        for (int i = 0; i < 6; i++) begin
            r[2*i]     = x[i];
            r[2*i + 1] = y[i];
        end
        return r;
    endfunction

endpackage

[rtl/htts_chan_wrap.sv]
// ============================================================================
// htts_chan_wrap
// Two-stage restoring remainder: wraps the signed channel into 0..depth-1.
// ============================================================================
module htts_chan_wrap import htts_pkg::*; (
    input  logic       aclk,
    input  logic [1:0] stage_en,
    input  cfg_t       cfg,
    input  logic [7:0] ch_raw,
    input  logic [5:0] px_in,
    input  logic [5:0] py_in,
    output logic [7:0] ch_out,
    output logic [5:0] px_out,
    output logic [5:0] py_out
);

    logic [7:0] mag;
    logic [7:0] r1_next;
    logic [7:0] r2;
    logic [7:0] ch_next;

    logic [7:0] s1_rem_reg;
    logic [3:0] s1_mag_lo_reg;
    logic       s1_neg_reg;
    logic [5:0] s1_px_reg;
    logic [5:0] s1_py_reg;
    logic [7:0] s2_ch_reg;
    logic [5:0] s2_px_reg;
    logic [5:0] s2_py_reg;

    always_comb begin
        logic [7:0] t;
        mag = ch_raw[7] ? 8'(9'd256 - {1'b0, ch_raw}) : ch_raw;
        t = mod_step(8'd0, mag[7], cfg.channel_count);
        t = mod_step(t, mag[6], cfg.channel_count);
        t = mod_step(t, mag[5], cfg.channel_count);
        r1_next = mod_step(t, mag[4], cfg.channel_count);
    end

    always_comb begin
        logic [7:0] t;
        t = mod_step(s1_rem_reg, s1_mag_lo_reg[3], cfg.channel_count);
        t = mod_step(t, s1_mag_lo_reg[2], cfg.channel_count);
        t = mod_step(t, s1_mag_lo_reg[1], cfg.channel_count);
        r2 = mod_step(t, s1_mag_lo_reg[0], cfg.channel_count);
        if (cfg.channel_count == 8'd0) begin
            ch_next = 8'd0;
        end else if (s1_neg_reg && r2 != 8'd0) begin
            ch_next = cfg.channel_count - r2;
        end else begin
            ch_next = r2;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_rem_reg    <= r1_next;
            s1_mag_lo_reg <= mag[3:0];
            s1_neg_reg    <= ch_raw[7];
            s1_px_reg     <= px_in;
            s1_py_reg     <= py_in;
        end
        if (stage_en[1]) begin
            s2_ch_reg <= ch_next;
            s2_px_reg <= s1_px_reg;
            s2_py_reg <= s1_py_reg;
        end
    end

    assign ch_out = s2_ch_reg;
    assign px_out = s2_px_reg;
    assign py_out = s2_py_reg;

endmodule

[rtl/htts_seed_mix.sv]
// ============================================================================
// htts_seed_mix
// Seed build, two-multiply finaliser and keyed tile offsets, five stages.
// ============================================================================
module htts_seed_mix import htts_pkg::*; (
    input  logic        aclk,
    input  logic [4:0]  stage_en,
    input  cfg_t        cfg,
    input  logic [7:0]  ch_in,
    input  logic [5:0]  px_in,
    input  logic [5:0]  py_in,
    output logic [31:0] seed_out,
    output logic [5:0]  off_x_out,
    output logic [5:0]  off_y_out,
    output logic [5:0]  px_out,
    output logic [5:0]  py_out
);

    logic [31:0] v3_next;
    logic [31:0] m4_next;
    logic [31:0] m5_next;
    logic [31:0] seed6;
    logic [31:0] pk6;
    logic [31:0] pk7;

    logic [31:0] s3_v_reg;
    logic [31:0] s4_m_reg;
    logic [31:0] s5_m_reg;
    logic [31:0] s6_seed_reg;
    logic [5:0]  s6_offa_x_reg;
    logic [5:0]  s6_offa_y_reg;
    logic [31:0] s7_seed_reg;
    logic [5:0]  s7_off_x_reg;
    logic [5:0]  s7_off_y_reg;
    logic [5:0]  px_reg [5];
    logic [5:0]  py_reg [5];

    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = cfg.frame_index * GOLD_MUL;
        b = (32'(ch_in) + 32'd1) * CHAN_MUL;
        c = (32'(cfg.channel_count) + 32'd1) * DEPTH_MUL;
        v3_next = a ^ b ^ c;
    end

    assign m4_next = (s3_v_reg ^ (s3_v_reg >> 16)) * MIX_MUL_A;
    assign m5_next = (s4_m_reg ^ (s4_m_reg >> 15)) * MIX_MUL_B;
    assign seed6   = s5_m_reg ^ (s5_m_reg >> 16);
    assign pk6     = seed6 ^ GOLD_MUL;
    assign pk7     = s6_seed_reg ^ GOLD_MUL;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s3_v_reg  <= v3_next;
            px_reg[0] <= px_in;
            py_reg[0] <= py_in;
        end
        if (stage_en[1]) begin
            s4_m_reg  <= m4_next;
            px_reg[1] <= px_reg[0];
            py_reg[1] <= py_reg[0];
        end
        if (stage_en[2]) begin
            s5_m_reg  <= m5_next;
            px_reg[2] <= px_reg[1];
            py_reg[2] <= py_reg[1];
        end
        if (stage_en[3]) begin
            s6_seed_reg   <= seed6;
            s6_offa_x_reg <= perm6_a(cfg.frame_index[5:0] + OFFX_ADD[5:0], pk6[5:0]);
            s6_offa_y_reg <= perm6_a(cfg.frame_index[5:0] ^ OFFY_XOR[5:0], pk6[12:7]);
            px_reg[3]     <= px_reg[2];
            py_reg[3]     <= py_reg[2];
        end
        if (stage_en[4]) begin
            s7_seed_reg  <= s6_seed_reg;
            s7_off_x_reg <= perm6_b(s6_offa_x_reg, pk7[14:9]);
            s7_off_y_reg <= perm6_b(s6_offa_y_reg, pk7[21:16]);
            px_reg[4]    <= px_reg[3];
            py_reg[4]    <= py_reg[3];
        end
    end

    assign seed_out  = s7_seed_reg;
    assign off_x_out = s7_off_x_reg;
    assign off_y_out = s7_off_y_reg;
    assign px_out    = px_reg[4];
    assign py_out    = py_reg[4];

endmodule

[rtl/htts_tile_rank.sv]
// ============================================================================
// htts_tile_rank
// Tile scramble, Morton rank, rank permutation, jitter and scaling, five stages.
// ============================================================================
module htts_tile_rank import htts_pkg::*; (
    input  logic        aclk,
    input  logic [4:0]  stage_en,
    input  logic [31:0] seed_in,
    input  logic [5:0]  off_x_in,
    input  logic [5:0]  off_y_in,
    input  logic [5:0]  px_in,
    input  logic [5:0]  py_in,
    output logic [15:0] threshold
);

    logic [5:0]  sx;
    logic [5:0]  sy;
    logic [31:0] kx8;
    logic [31:0] ky8;
    logic [31:0] jseed8;
    logic [31:0] kx9;
    logic [31:0] ky9;
    logic [31:0] rk10;
    logic [31:0] rk11;
    logic [11:0] rank12;
    logic [28:0] scaled;

    logic [31:0] s8_seed_reg;
    logic [5:0]  s8_scra_x_reg;
    logic [5:0]  s8_scra_y_reg;
    logic [31:0] s8_j_reg;
    logic [31:0] s9_seed_reg;
    logic [5:0]  s9_scr_x_reg;
    logic [5:0]  s9_scr_y_reg;
    logic [31:0] s9_j_reg;
    logic [31:0] s10_seed_reg;
    logic [11:0] s10_rank_reg;
    logic [31:0] s10_j_reg;
    logic [11:0] s11_rank_reg;
    logic [5:0]  s11_jit_reg;
    logic [15:0] s12_thr_reg;

    assign sx     = px_in + off_x_in;
    assign sy     = py_in + off_y_in;
    assign kx8    = seed_in ^ SCRAMBLE_SALT ^ SCRX_KEY;
    assign ky8    = seed_in ^ SCRAMBLE_SALT ^ SCRY_KEY;
    assign jseed8 = seed_in ^ (32'(sx) * JIT_X_MUL) ^ (32'(sy) * JIT_Y_MUL);
    assign kx9    = s8_seed_reg ^ SCRAMBLE_SALT ^ SCRX_KEY;
    assign ky9    = s8_seed_reg ^ SCRAMBLE_SALT ^ SCRY_KEY;
    assign rk10   = s9_seed_reg ^ RANK_KEY;
    assign rk11   = s10_seed_reg ^ RANK_KEY;
    assign rank12 = s11_rank_reg + {6'd0, s11_jit_reg};
    assign scaled = 29'(rank12) * SCALE_MUL + SCALE_ROUND;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s8_seed_reg   <= seed_in;
            s8_scra_x_reg <= perm6_a(sx, kx8[5:0]);
            s8_scra_y_reg <= perm6_a(sy, ky8[5:0]);
            s8_j_reg      <= jseed8;
        end
        if (stage_en[1]) begin
            s9_seed_reg  <= s8_seed_reg;
            s9_scr_x_reg <= perm6_b(s8_scra_x_reg, kx9[14:9]);
            s9_scr_y_reg <= perm6_b(s8_scra_y_reg, ky9[14:9]);
            s9_j_reg     <= (s8_j_reg ^ (s8_j_reg >> 16)) * MIX_MUL_A;
        end
        if (stage_en[2]) begin
            s10_seed_reg <= s9_seed_reg;
            s10_rank_reg <= perm12_a(interleave6(s9_scr_x_reg, s9_scr_y_reg), rk10[11:0]);
            s10_j_reg    <= (s9_j_reg ^ (s9_j_reg >> 15)) * MIX_MUL_B;
        end
        if (stage_en[3]) begin
            s11_rank_reg <= perm12_b(s10_rank_reg, rk11[20:9]);
            s11_jit_reg  <= s10_j_reg[5:0] ^ s10_j_reg[21:16];
        end
        if (stage_en[4]) begin
            s12_thr_reg <= scaled[27:12];
        end
    end

    assign threshold = s12_thr_reg;

endmodule

[rtl/hashed_tile_threshold_sample_core.sv]
// ============================================================================
// hashed_tile_threshold_sample_core
// Per-pixel hashed tile dither threshold, twelve-stage pipeline.
// ============================================================================
// Input words on s_* carry a pixel position and a channel number; each yields
// one 16-bit threshold word on m_*. Frame index and channel count are set
// through the cfg_* write port; the user must do so only while the core is
// empty (not enforced by the core); they apply to every word that follows.
// Pipeline: twelve register stages (two remainder stages, five seed/offset
// stages, five rank stages, the last being the output register).
// Throughput: one word per cycle while m_tready is high; no stage chains two multiplies.
// A stage advances when it is empty or the next one advances, so bubbles
// close up and s_tready stays high while any stage is free. When m_tready is
// low the output word holds and the pipe fills behind it; nothing is lost
// or repeated.
// Reset (aresetn low, synchronous) empties the pipe and sets frame index to
// 0 and channel count to 1.
// ============================================================================
module hashed_tile_threshold_sample_core import htts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_x[15:0], pixel_y[31:16], channel_number[39:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // threshold[15:0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfg_t              cfg;
    logic [31:0]       frame_index_reg;
    logic [7:0]        channel_count_reg;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] valid_in;
    logic [NSTAGE-1:0] adv;

    logic [7:0]  w_ch;
    logic [5:0]  w_px;
    logic [5:0]  w_py;
    logic [31:0] m_seed;
    logic [5:0]  m_off_x;
    logic [5:0]  m_off_y;
    logic [5:0]  m_px;
    logic [5:0]  m_py;

    assign cfg.frame_index   = frame_index_reg;
    assign cfg.channel_count = channel_count_reg;

    assign valid_in = {valid_reg[NSTAGE-2:0], s_tvalid};

    always_comb begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        for (int i = 0; i < NSTAGE; i++) begin
            valid_next[i] = adv[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg         <= '0;
            frame_index_reg   <= 32'd0;
            channel_count_reg <= 8'd1;
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FRAME_INDEX:   frame_index_reg   <= cfg_wdata;
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[7:0];
                endcase
            end
        end
    end

    htts_chan_wrap u_chan_wrap (
        .aclk     (aclk),
        .stage_en (adv[1:0]),
        .cfg      (cfg),
        .ch_raw   (s_tdata[39:32]),
        .px_in    (s_tdata[5:0]),
        .py_in    (s_tdata[21:16]),
        .ch_out   (w_ch),
        .px_out   (w_px),
        .py_out   (w_py)
    );

    htts_seed_mix u_seed_mix (
        .aclk      (aclk),
        .stage_en  (adv[6:2]),
        .cfg       (cfg),
        .ch_in     (w_ch),
        .px_in     (w_px),
        .py_in     (w_py),
        .seed_out  (m_seed),
        .off_x_out (m_off_x),
        .off_y_out (m_off_y),
        .px_out    (m_px),
        .py_out    (m_py)
    );

    htts_tile_rank u_tile_rank (
        .aclk      (aclk),
        .stage_en  (adv[11:7]),
        .seed_in   (m_seed),
        .off_x_in  (m_off_x),
        .off_y_in  (m_off_y),
        .px_in     (m_px),
        .py_in     (m_py),
        .threshold (m_tdata)
    );

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

endmodule

[rtl/htts_checker.sv]
// ============================================================================
// htts_checker
// Port-level checks for the tile threshold core, bound to the top level.
// ============================================================================
module htts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // pipe is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // a free output always lets the whole pipe advance
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

endmodule

bind hashed_tile_threshold_sample_core htts_checker u_htts_checker (.*);
